// ===== hw/rtl/inelastic_collision_response_defines.svh =====
// assertion macros shared by the rtl
`ifndef INELASTIC_COLLISION_RESPONSE_DEFINES_SVH
`define INELASTIC_COLLISION_RESPONSE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define ICR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ICR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/icr_pkg.sv =====
package icr_pkg;

    localparam int VEL_W   = 24;
    localparam int MASS_W  = 16;
    localparam int REST_W  = 17;
    localparam int LANES   = 4;

    localparam logic [REST_W-1:0] REST_ONE   = 17'd65536;
    localparam logic [REST_W-1:0] REST_RESET = 17'd45875;

    // widths of the datapath
    localparam int KP_W   = REST_W + 1;          // 1 + C in Q2.16
    localparam int PRD_W  = 2 * VEL_W;           // direction times velocity
    localparam int DD_W   = 2 * VEL_W;           // squared direction length
    localparam int DOT_W  = 2 * VEL_W + 1;       // dot product
    localparam int DMAG_W = 2 * VEL_W + 2;       // magnitude of dot difference
    localparam int MSUM_W = MASS_W + 1;
    localparam int K_W    = MASS_W + KP_W;       // mass times (1 + C)
    localparam int A_W    = VEL_W + K_W;         // |d| times k
    localparam int AL_W   = 29;
    localparam int AH_W   = A_W - AL_W;
    localparam int DL_W   = 25;
    localparam int DH_W   = DMAG_W - DL_W;
    localparam int PP_W   = 54;                  // one partial product
    localparam int NUM_W  = A_W + DMAG_W;        // dividend
    localparam int DEN_W  = 80;                  // divisor
    localparam int REM_W  = DEN_W;
    localparam int Q_W    = 27;                  // quotient bits
    localparam int CORR_W = Q_W + 1;
    localparam int SUM_W  = CORR_W + 1;

    localparam int IN_W   = 6 * VEL_W + 2 * MASS_W;
    localparam int OUT_W  = 4 * VEL_W;
    localparam int USER_W = 2;

    // pipeline stage numbers
    localparam int DIV_BASE = 6;                 // stage of the dividend register
    localparam int RND_STG  = DIV_BASE + Q_W + 1;
    localparam int NST      = RND_STG + 1;

    // lane order
    localparam int LANE_AX = 0;
    localparam int LANE_AY = 1;
    localparam int LANE_BX = 2;
    localparam int LANE_BY = 3;

    // output tuser bits
    localparam int USER_DEGEN = 0;
    localparam int USER_SAT   = 1;

endpackage

// ===== hw/rtl/inelastic_collision_response.sv =====
// throughput: one item per cycle unless the output stalls with the pipeline full; the
// 27-stage restoring quotient pipeline (one quotient bit per stage, four lanes) sets the depth
// stalls only freeze stages up to the nearest bubble
// reset (rst_n low, asynchronous): pipeline valid bits clear, restitution
// returns to 45875 (0.7)
`include "inelastic_collision_response_defines.svh"

module inelastic_collision_response
(
    input  logic                          clk,
    input  logic                          rst_n,

    // restitution register, Q1.16
    input  logic                          cfg_we,
    input  logic [icr_pkg::REST_W-1:0]    cfg_wdata,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // dir_x, dir_y, mass_a, mass_b, vel_a_x, vel_a_y, vel_b_x, vel_b_y
    input  logic [icr_pkg::IN_W-1:0]      s_tdata,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // new_a_x, new_a_y, new_b_x, new_b_y
    output logic [icr_pkg::OUT_W-1:0]     m_tdata,
    // degenerate, saturated
    output logic [icr_pkg::USER_W-1:0]    m_tuser
);

    import icr_pkg::*;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [REST_W-1:0] rest_reg;
    logic [REST_W-1:0] rest_c;
    logic [KP_W-1:0]   kp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= REST_RESET;
        end
        else if (cfg_we)
        begin
            rest_reg <= cfg_wdata;
        end
    end

    // coefficients above one clamp to one
    assign rest_c = (rest_reg > REST_ONE) ? REST_ONE : rest_reg;
    assign kp     = KP_W'(REST_ONE) + KP_W'(rest_c);

    // ------------------------------------------------------------------
    // flow control: a stage moves when it or any later stage is empty or the
    // output is taken
    // ------------------------------------------------------------------
    logic [NST:1] vld_reg;
    logic [NST:1] vld_in;
    logic [NST:1] en;

    assign vld_in = {vld_reg[NST-1:1], s_tvalid};

    always_comb
    begin
        logic [NST:1] tail;
        for (int j = 1; j <= NST; j++)
        begin
            tail = vld_reg;
            for (int k = 1; k < j; k++)
            begin
                tail[k] = 1'b1;
            end
            en[j] = m_tready || !(&tail);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int j = 1; j <= NST; j++)
            begin
                if (en[j])
                begin
                    vld_reg[j] <= vld_in[j];
                end
            end
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = vld_reg[NST];

    // ------------------------------------------------------------------
    // input unpacking
    // ------------------------------------------------------------------
    logic signed [VEL_W-1:0] dx, dy;
    logic [MASS_W-1:0]       ma, mb;
    logic signed [VEL_W-1:0] vin [LANES];
    logic [VEL_W-1:0]        dxm, dym;

    assign dx             = s_tdata[VEL_W-1:0];
    assign dy             = s_tdata[2*VEL_W-1:VEL_W];
    assign ma             = s_tdata[2*VEL_W+MASS_W-1:2*VEL_W];
    assign mb             = s_tdata[2*VEL_W+2*MASS_W-1:2*VEL_W+MASS_W];
    assign vin[LANE_AX]   = s_tdata[3*VEL_W+2*MASS_W-1:2*VEL_W+2*MASS_W];
    assign vin[LANE_AY]   = s_tdata[4*VEL_W+2*MASS_W-1:3*VEL_W+2*MASS_W];
    assign vin[LANE_BX]   = s_tdata[5*VEL_W+2*MASS_W-1:4*VEL_W+2*MASS_W];
    assign vin[LANE_BY]   = s_tdata[6*VEL_W+2*MASS_W-1:5*VEL_W+2*MASS_W];
    assign dxm            = dx[VEL_W-1] ? (~dx + 1'b1) : dx;
    assign dym            = dy[VEL_W-1] ? (~dy + 1'b1) : dy;

    // ------------------------------------------------------------------
    // stage 1: direction and dot-product multiplies
    // ------------------------------------------------------------------
    logic signed [PRD_W-1:0] s1_dxdx_reg, s1_dydy_reg;
    logic signed [PRD_W-1:0] s1_dxa_reg, s1_dya_reg, s1_dxb_reg, s1_dyb_reg;
    logic [MSUM_W-1:0]       s1_msum_reg;
    logic [KP_W-1:0]         s1_kp_reg;
    logic [MASS_W-1:0]       s1_ma_reg, s1_mb_reg;
    logic [VEL_W-1:0]        s1_dxm_reg, s1_dym_reg;
    logic                    s1_dxn_reg, s1_dyn_reg, s1_degen_reg;
    logic signed [VEL_W-1:0] s1_vel_reg [LANES];

    // ------------------------------------------------------------------
    // stage 2: squared length, dot products, mass weights
    // ------------------------------------------------------------------
    logic [DD_W-1:0]         s2_dd_reg;
    logic signed [DOT_W-1:0] s2_dota_reg, s2_dotb_reg;
    logic [K_W-1:0]          s2_ka_reg, s2_kb_reg;
    logic [MSUM_W-1:0]       s2_msum_reg;
    logic [VEL_W-1:0]        s2_dxm_reg, s2_dym_reg;
    logic                    s2_dxn_reg, s2_dyn_reg, s2_degen_reg;
    logic signed [VEL_W-1:0] s2_vel_reg [LANES];

    logic [DD_W-1:0]         dd_next;
    logic signed [DOT_W-1:0] dota_next, dotb_next;

    assign dd_next   = DD_W'($unsigned(s1_dxdx_reg)) + DD_W'($unsigned(s1_dydy_reg));
    assign dota_next = DOT_W'(s1_dxa_reg) + DOT_W'(s1_dya_reg);
    assign dotb_next = DOT_W'(s1_dxb_reg) + DOT_W'(s1_dyb_reg);

    // ------------------------------------------------------------------
    // stage 3: difference of projections, divisor
    // ------------------------------------------------------------------
    logic [DMAG_W-1:0]       s3_dmag_reg;
    logic                    s3_dneg_reg;
    logic [DEN_W-1:0]        s3_den_reg;
    logic [K_W-1:0]          s3_ka_reg, s3_kb_reg;
    logic [VEL_W-1:0]        s3_dxm_reg, s3_dym_reg;
    logic                    s3_dxn_reg, s3_dyn_reg, s3_degen_reg, s3_pass_reg;
    logic signed [VEL_W-1:0] s3_vel_reg [LANES];

    logic signed [DMAG_W-1:0] diff;
    logic [DMAG_W-1:0]        dmag_next;
    logic [DD_W+MSUM_W-1:0]   ddm;

    assign diff      = DMAG_W'(s2_dotb_reg) - DMAG_W'(s2_dota_reg);
    assign dmag_next = diff[DMAG_W-1] ? (~diff + 1'b1) : diff;
    assign ddm       = s2_dd_reg * s2_msum_reg;

    // ------------------------------------------------------------------
    // stage 4: |d component| times mass weight, per lane
    // ------------------------------------------------------------------
    logic [A_W-1:0]          s4_a_reg [LANES];
    logic                    s4_neg_reg [LANES];
    logic [DMAG_W-1:0]       s4_dmag_reg;
    logic [DEN_W-1:0]        s4_den_reg;
    logic                    s4_degen_reg, s4_pass_reg;
    logic signed [VEL_W-1:0] s4_vel_reg [LANES];

    logic [A_W-1:0] a_next [LANES];
    logic           neg_next [LANES];

    always_comb
    begin
        a_next[LANE_AX]   = s3_dxm_reg * s3_ka_reg;
        a_next[LANE_AY]   = s3_dym_reg * s3_ka_reg;
        a_next[LANE_BX]   = s3_dxm_reg * s3_kb_reg;
        a_next[LANE_BY]   = s3_dym_reg * s3_kb_reg;
        // body a moves along +diff, body b against it
        neg_next[LANE_AX] = s3_dxn_reg != s3_dneg_reg;
        neg_next[LANE_AY] = s3_dyn_reg != s3_dneg_reg;
        neg_next[LANE_BX] = s3_dxn_reg == s3_dneg_reg;
        neg_next[LANE_BY] = s3_dyn_reg == s3_dneg_reg;
    end

    // ------------------------------------------------------------------
    // stage 5: partial products of the dividend
    // ------------------------------------------------------------------
    logic [PP_W-1:0]         s5_hh_reg [LANES];
    logic [PP_W-1:0]         s5_hl_reg [LANES];
    logic [PP_W-1:0]         s5_lh_reg [LANES];
    logic [PP_W-1:0]         s5_ll_reg [LANES];
    logic                    s5_neg_reg [LANES];
    logic [DEN_W-1:0]        s5_den_reg;
    logic                    s5_degen_reg, s5_pass_reg;
    logic signed [VEL_W-1:0] s5_vel_reg [LANES];

    // ------------------------------------------------------------------
    // stages 6..33: dividend register, then one quotient bit per stage
    // ------------------------------------------------------------------
    logic [REM_W-1:0]        dv_rem_reg  [Q_W+1][LANES];
    logic [Q_W-1:0]          dv_low_reg  [Q_W+1][LANES];
    logic [Q_W-1:0]          dv_q_reg    [Q_W+1][LANES];
    logic                    dv_neg_reg  [Q_W+1][LANES];
    logic signed [VEL_W-1:0] dv_vel_reg  [Q_W+1][LANES];
    logic [DEN_W-1:0]        dv_den_reg  [Q_W+1];
    logic                    dv_degen_reg [Q_W+1];
    logic                    dv_pass_reg  [Q_W+1];

    logic [REM_W-1:0] dv_rem_next [Q_W+1][LANES];
    logic [Q_W-1:0]   dv_low_next [Q_W+1][LANES];
    logic [Q_W-1:0]   dv_q_next   [Q_W+1][LANES];

    always_comb
    begin
        logic [NUM_W-1:0] num;
        logic [REM_W:0]   t;
        logic [REM_W:0]   dsub;
        logic             ge;
        for (int l = 0; l < LANES; l++)
        begin
            num = (NUM_W'(s5_hh_reg[l]) << (AL_W + DL_W))
                + (NUM_W'(s5_hl_reg[l]) << AL_W)
                + (NUM_W'(s5_lh_reg[l]) << DL_W)
                + NUM_W'(s5_ll_reg[l]);
            // quotient stays below 2^Q_W, so the high part is below the divisor
            dv_rem_next[0][l] = num[NUM_W-2:Q_W];
            dv_low_next[0][l] = num[Q_W-1:0];
            dv_q_next[0][l]   = '0;
        end
        for (int k = 1; k <= Q_W; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                t    = {dv_rem_reg[k-1][l], dv_low_reg[k-1][l][Q_W-1]};
                dsub = t - {1'b0, dv_den_reg[k-1]};
                ge   = t >= {1'b0, dv_den_reg[k-1]};
                dv_rem_next[k][l] = ge ? dsub[REM_W-1:0] : t[REM_W-1:0];
                dv_low_next[k][l] = {dv_low_reg[k-1][l][Q_W-2:0], 1'b0};
                dv_q_next[k][l]   = {dv_q_reg[k-1][l][Q_W-2:0], ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 34: round to nearest, ties away from zero, apply sign
    // ------------------------------------------------------------------
    logic signed [CORR_W-1:0] rd_corr_reg [LANES];
    logic signed [VEL_W-1:0]  rd_vel_reg  [LANES];
    logic                     rd_degen_reg, rd_pass_reg;

    logic signed [CORR_W-1:0] corr_next [LANES];

    always_comb
    begin
        logic [Q_W-1:0] mag;
        logic           up;
        for (int l = 0; l < LANES; l++)
        begin
            up  = {dv_rem_reg[Q_W][l], 1'b0} >= {1'b0, dv_den_reg[Q_W]};
            mag = dv_q_reg[Q_W][l] + Q_W'(up);
            corr_next[l] = dv_neg_reg[Q_W][l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    // ------------------------------------------------------------------
    // stage 35: add, saturate, output register
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] out_data_reg;
    logic             out_degen_reg, out_sat_reg;

    logic [OUT_W-1:0] out_data_next;
    logic             out_sat_next;

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic [VEL_W-1:0]        res;
        logic                    clip;
        out_sat_next  = 1'b0;
        out_data_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            sum  = SUM_W'(rd_vel_reg[l]) + SUM_W'(rd_corr_reg[l]);
            clip = !((&sum[SUM_W-1:VEL_W-1]) || !(|sum[SUM_W-1:VEL_W-1]));
            if (rd_degen_reg || rd_pass_reg)
            begin
                res  = rd_vel_reg[l];
                clip = 1'b0;
            end
            else if (clip)
            begin
                res = {sum[SUM_W-1], {(VEL_W-1){!sum[SUM_W-1]}}};
            end
            else
            begin
                res = sum[VEL_W-1:0];
            end
            out_data_next[l*VEL_W +: VEL_W] = res;
            out_sat_next = out_sat_next | clip;
        end
    end

    assign m_tdata              = out_data_reg;
    assign m_tuser[USER_DEGEN]  = out_degen_reg;
    assign m_tuser[USER_SAT]    = out_sat_reg;

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_dxdx_reg  <= dx * dx;
            s1_dydy_reg  <= dy * dy;
            s1_dxa_reg   <= dx * vin[LANE_AX];
            s1_dya_reg   <= dy * vin[LANE_AY];
            s1_dxb_reg   <= dx * vin[LANE_BX];
            s1_dyb_reg   <= dy * vin[LANE_BY];
            s1_msum_reg  <= MSUM_W'(ma) + MSUM_W'(mb);
            s1_kp_reg    <= kp;
            s1_ma_reg    <= ma;
            s1_mb_reg    <= mb;
            s1_dxm_reg   <= dxm;
            s1_dym_reg   <= dym;
            s1_dxn_reg   <= dx[VEL_W-1];
            s1_dyn_reg   <= dy[VEL_W-1];
            s1_degen_reg <= (dx == '0) && (dy == '0);
            s1_vel_reg   <= vin;
        end
        if (en[2])
        begin
            s2_dd_reg    <= dd_next;
            s2_dota_reg  <= dota_next;
            s2_dotb_reg  <= dotb_next;
            s2_ka_reg    <= s1_mb_reg * s1_kp_reg;
            s2_kb_reg    <= s1_ma_reg * s1_kp_reg;
            s2_msum_reg  <= s1_msum_reg;
            s2_dxm_reg   <= s1_dxm_reg;
            s2_dym_reg   <= s1_dym_reg;
            s2_dxn_reg   <= s1_dxn_reg;
            s2_dyn_reg   <= s1_dyn_reg;
            s2_degen_reg <= s1_degen_reg;
            s2_vel_reg   <= s1_vel_reg;
        end
        if (en[3])
        begin
            s3_dmag_reg  <= dmag_next;
            s3_dneg_reg  <= diff[DMAG_W-1];
            s3_den_reg   <= {ddm[DEN_W-MASS_W-1:0], {MASS_W{1'b0}}};
            s3_ka_reg    <= s2_ka_reg;
            s3_kb_reg    <= s2_kb_reg;
            s3_dxm_reg   <= s2_dxm_reg;
            s3_dym_reg   <= s2_dym_reg;
            s3_dxn_reg   <= s2_dxn_reg;
            s3_dyn_reg   <= s2_dyn_reg;
            s3_degen_reg <= s2_degen_reg;
            // both masses zero: no correction
            s3_pass_reg  <= s2_msum_reg == '0;
            s3_vel_reg   <= s2_vel_reg;
        end
        if (en[4])
        begin
            s4_a_reg     <= a_next;
            s4_neg_reg   <= neg_next;
            s4_dmag_reg  <= s3_dmag_reg;
            s4_den_reg   <= s3_den_reg;
            s4_degen_reg <= s3_degen_reg;
            s4_pass_reg  <= s3_pass_reg;
            s4_vel_reg   <= s3_vel_reg;
        end
        if (en[5])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                s5_hh_reg[l] <= PP_W'(s4_a_reg[l][A_W-1:AL_W] * s4_dmag_reg[DMAG_W-1:DL_W]);
                s5_hl_reg[l] <= PP_W'(s4_a_reg[l][A_W-1:AL_W] * s4_dmag_reg[DL_W-1:0]);
                s5_lh_reg[l] <= PP_W'(s4_a_reg[l][AL_W-1:0] * s4_dmag_reg[DMAG_W-1:DL_W]);
                s5_ll_reg[l] <= PP_W'(s4_a_reg[l][AL_W-1:0] * s4_dmag_reg[DL_W-1:0]);
            end
            s5_neg_reg   <= s4_neg_reg;
            s5_den_reg   <= s4_den_reg;
            s5_degen_reg <= s4_degen_reg;
            s5_pass_reg  <= s4_pass_reg;
            s5_vel_reg   <= s4_vel_reg;
        end
        for (int k = 0; k <= Q_W; k++)
        begin
            if (en[DIV_BASE + k])
            begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_low_reg[k] <= dv_low_next[k];
                dv_q_reg[k]   <= dv_q_next[k];
                if (k == 0)
                begin
                    dv_neg_reg[k]   <= s5_neg_reg;
                    dv_vel_reg[k]   <= s5_vel_reg;
                    dv_den_reg[k]   <= s5_den_reg;
                    dv_degen_reg[k] <= s5_degen_reg;
                    dv_pass_reg[k]  <= s5_pass_reg;
                end
                else
                begin
                    dv_neg_reg[k]   <= dv_neg_reg[k-1];
                    dv_vel_reg[k]   <= dv_vel_reg[k-1];
                    dv_den_reg[k]   <= dv_den_reg[k-1];
                    dv_degen_reg[k] <= dv_degen_reg[k-1];
                    dv_pass_reg[k]  <= dv_pass_reg[k-1];
                end
            end
        end
        if (en[RND_STG])
        begin
            rd_corr_reg  <= corr_next;
            rd_vel_reg   <= dv_vel_reg[Q_W];
            rd_degen_reg <= dv_degen_reg[Q_W];
            rd_pass_reg  <= dv_pass_reg[Q_W];
        end
        if (en[NST])
        begin
            out_data_reg  <= out_data_next;
            out_degen_reg <= rd_degen_reg;
            out_sat_reg   <= out_sat_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a zero direction passes velocities through, so nothing can clip
    `ICR_ASSERT_NOW(a_degen_no_sat, m_tvalid && m_tuser[USER_DEGEN],
        !m_tuser[USER_SAT], "degenerate result flagged as saturated")
    // a full pipeline with a stalled output must hold off the slave side
    `ICR_ASSERT_NOW(a_full_stall, (&vld_reg) && !m_tready, !s_tready,
        "input taken while pipeline full and stalled")
    // every input transfer occupies the first stage
    `ICR_ASSERT_NEXT(a_enter, s_tvalid && s_tready, vld_reg[1],
        "accepted transfer lost at pipeline entry")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import icr_pkg::*;

    localparam int PERIOD     = 20;
    localparam int DRAIN_WAIT = 45;    // pipeline depth plus margin
    localparam int N_RANDOM   = 1200;

    localparam logic signed [VEL_W-1:0] V_MAX = 24'sh7FFFFF;
    localparam logic signed [VEL_W-1:0] V_MIN = -24'sh800000;
    localparam logic signed [VEL_W-1:0] ONE_Q = 24'sh010000;

    typedef struct {
        logic signed [VEL_W-1:0] dir_x;
        logic signed [VEL_W-1:0] dir_y;
        logic [MASS_W-1:0]       mass_a;
        logic [MASS_W-1:0]       mass_b;
        logic signed [VEL_W-1:0] vel [LANES];
    } pair_t;

    typedef struct {
        logic [VEL_W-1:0] vel [LANES];
        logic             degen;
        logic             sat;
    } outcome_t;

    typedef struct {
        pair_t    pair;
        bit       typed;
        outcome_t want;
    } row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [REST_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic [USER_W-1:0] m_tuser;

    // restitution as the model of the block holds it
    logic [REST_W-1:0] rest_coef;
    outcome_t          pending_q [$];
    row_t              directed [$];
    int                n_errors;
    int                rx_stall;
    bit                tx_busy_mode;   // no gaps on the slave side
    bit                rx_busy_mode;   // no stalls on the master side

    inelastic_collision_response uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(PERIOD / 2) clk = ~clk;

    // safety net against a hung handshake
    initial
    begin
        #(20_000_000);
        $display("tb: FAIL");
        $finish;
    end

    // one lane correction: exact quotient rounded half away from zero, capped
    function automatic longint lane_corr(longint dcomp, bit neg, longint dmag,
                                         longint k, bit [127:0] den);
        bit [127:0] num;
        bit [127:0] quo;
        bit [127:0] rem;
        longint     mag;
        num = 128'(dmag) * 128'(k) * 128'(dcomp < 0 ? -dcomp : dcomp);
        quo = num / den;
        rem = num - quo * den;
        if ((rem << 1) >= den)
            quo = quo + 1;
        mag = (quo > 128'd1099511627776) ? 64'd1099511627776 : longint'(quo);
        return ((dcomp < 0) != neg) ? -mag : mag;
    endfunction

    // collision response of one pair under the current restitution
    function automatic outcome_t collide(pair_t p);
        outcome_t   res;
        longint     dx;
        longint     dy;
        longint     v [LANES];
        longint     r [LANES];
        longint     c;
        longint     dd;
        longint     s1;
        longint     s2;
        longint     diff;
        longint     ka;
        longint     kb;
        bit [127:0] den;
        bit         dneg;
        dx = p.dir_x;
        dy = p.dir_y;
        res.degen = 1'b0;
        res.sat   = 1'b0;
        for (int j = 0; j < LANES; j++)
        begin
            v[j] = p.vel[j];
            r[j] = v[j];
        end
        if (dx == 0 && dy == 0)
            res.degen = 1'b1;
        else if (p.mass_a + p.mass_b != 0)
        begin
            c    = (rest_coef > REST_ONE) ? longint'(REST_ONE) : longint'(rest_coef);
            dd   = dx * dx + dy * dy;
            den  = 128'(dd) * 128'((longint'(p.mass_a) + longint'(p.mass_b)) << 16);
            s1   = dx * v[LANE_AX] + dy * v[LANE_AY];
            s2   = dx * v[LANE_BX] + dy * v[LANE_BY];
            diff = s2 - s1;
            dneg = diff < 0;
            if (dneg)
                diff = -diff;
            ka = longint'(p.mass_b) * (65536 + c);
            kb = longint'(p.mass_a) * (65536 + c);
            r[LANE_AX] = v[LANE_AX] + lane_corr(dx, dneg, diff, ka, den);
            r[LANE_AY] = v[LANE_AY] + lane_corr(dy, dneg, diff, ka, den);
            r[LANE_BX] = v[LANE_BX] + lane_corr(dx, !dneg, diff, kb, den);
            r[LANE_BY] = v[LANE_BY] + lane_corr(dy, !dneg, diff, kb, den);
            for (int j = 0; j < LANES; j++)
            begin
                if (r[j] > longint'(V_MAX))
                begin
                    r[j] = V_MAX;
                    res.sat = 1'b1;
                end
                else if (r[j] < longint'(V_MIN))
                begin
                    r[j] = V_MIN;
                    res.sat = 1'b1;
                end
            end
        end
        for (int j = 0; j < LANES; j++)
            res.vel[j] = r[j][VEL_W-1:0];
        return res;
    endfunction

    function automatic outcome_t unchanged(pair_t p, bit degen);
        outcome_t res;
        for (int j = 0; j < LANES; j++)
            res.vel[j] = p.vel[j];
        res.degen = degen;
        res.sat   = 1'b0;
        return res;
    endfunction

    function automatic pair_t mk_pair(logic signed [VEL_W-1:0] dx, logic signed [VEL_W-1:0] dy,
                                      logic [MASS_W-1:0] ma, logic [MASS_W-1:0] mb,
                                      logic signed [VEL_W-1:0] ax, logic signed [VEL_W-1:0] ay,
                                      logic signed [VEL_W-1:0] bx, logic signed [VEL_W-1:0] by);
        pair_t p;
        p.dir_x  = dx;
        p.dir_y  = dy;
        p.mass_a = ma;
        p.mass_b = mb;
        p.vel[LANE_AX] = ax;
        p.vel[LANE_AY] = ay;
        p.vel[LANE_BX] = bx;
        p.vel[LANE_BY] = by;
        return p;
    endfunction

    // row checked against the collision model
    task automatic add_row(pair_t p);
        row_t rw;
        rw.pair  = p;
        rw.typed = 1'b0;
        directed.push_back(rw);
    endtask

    // row with the result written out by hand
    task automatic add_typed(pair_t p, outcome_t want);
        row_t rw;
        rw.pair  = p;
        rw.typed = 1'b1;
        rw.want  = want;
        directed.push_back(rw);
    endtask

    function automatic logic signed [VEL_W-1:0] rand_vel();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) != 0) ? V_MAX : V_MIN;
            1, 2:    return VEL_W'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            default: return VEL_W'($urandom());
        endcase
    endfunction

    function automatic logic [MASS_W-1:0] rand_mass();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'd1;
            2:       return MASS_W'($urandom_range(1, 20));
            default: return MASS_W'($urandom_range(1, 16'hFFFF));
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        p.dir_x  = rand_vel();
        p.dir_y  = rand_vel();
        // a zero direction now and then
        if ($urandom_range(0, 40) == 0)
        begin
            p.dir_x = '0;
            p.dir_y = '0;
        end
        p.mass_a = rand_mass();
        p.mass_b = rand_mass();
        for (int j = 0; j < LANES; j++)
            p.vel[j] = rand_vel();
        return p;
    endfunction

    // one transfer on the slave side, then the sender's idle gap
    task automatic send_pair(pair_t p, bit typed, outcome_t want);
        int gap;
        @(negedge clk);
        s_tdata  <= {p.vel[LANE_BY], p.vel[LANE_BX], p.vel[LANE_AY], p.vel[LANE_AX],
                     p.mass_b, p.mass_a, p.dir_y, p.dir_x};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_q.push_back(typed ? want : collide(p));
        gap = tx_busy_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // lets the pipeline run dry so the register can change safely
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_rest(logic [REST_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        rest_coef = val;
    endtask

    // master side: random stall before each transfer
    always @(negedge clk)
    begin
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            outcome_t want;
            logic [OUT_W-1:0]  want_data;
            logic [USER_W-1:0] want_user;
            rx_stall <= rx_busy_mode ? 0 : $urandom_range(0, 14);
            if (pending_q.size() == 0)
            begin
                n_errors = n_errors + 1;
                if (n_errors <= 10)
                    $display("unexpected result transfer: data %h user %b", m_tdata, m_tuser);
            end
            else
            begin
                want = pending_q.pop_front();
                want_data = {want.vel[LANE_BY], want.vel[LANE_BX],
                             want.vel[LANE_AY], want.vel[LANE_AX]};
                want_user = '0;
                want_user[USER_DEGEN] = want.degen;
                want_user[USER_SAT]   = want.sat;
                if (m_tdata !== want_data || m_tuser !== want_user)
                begin
                    n_errors = n_errors + 1;
                    if (n_errors <= 10)
                    begin
                        for (int j = 0; j < LANES; j++)
                            if (m_tdata[j*VEL_W +: VEL_W] !== want.vel[j])
                                $display("lane %0d: expected %h got %h", j,
                                         want.vel[j], m_tdata[j*VEL_W +: VEL_W]);
                        if (m_tuser[USER_DEGEN] !== want.degen)
                            $display("degenerate: expected %b got %b",
                                     want.degen, m_tuser[USER_DEGEN]);
                        if (m_tuser[USER_SAT] !== want.sat)
                            $display("saturated: expected %b got %b",
                                     want.sat, m_tuser[USER_SAT]);
                    end
                end
            end
        end
    end

    initial
    begin
        // rest values walked after the directed part, the extremes among them
        logic [REST_W-1:0] rest_plan [6];
        pair_t    p;
        outcome_t none;
        int       n_sent;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        rx_stall     = 0;
        n_errors     = 0;
        tx_busy_mode = 1'b0;
        rx_busy_mode = 1'b0;
        rest_coef    = REST_RESET;
        none         = unchanged(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero direction: velocities pass untouched, degenerate set
        p = mk_pair(0, 0, 16'd100, 16'd200, V_MAX, V_MIN, V_MIN, V_MAX);
        add_typed(p, unchanged(p, 1'b1));
        p = mk_pair(0, 0, 16'hFFFF, 16'd1, ONE_Q, -ONE_Q, 24'sh123456, 24'sh5A5A5A);
        add_typed(p, unchanged(p, 1'b1));
        // both masses zero: no correction, not degenerate
        p = mk_pair(ONE_Q, ONE_Q, 16'd0, 16'd0, V_MAX, V_MIN, ONE_Q, -ONE_Q);
        add_typed(p, unchanged(p, 1'b0));
        // equal velocities: nothing to exchange
        p = mk_pair(ONE_Q, 0, 16'd5, 16'd7, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
        add_typed(p, unchanged(p, 1'b0));
        // head-on along x, equal masses
        add_row(mk_pair(ONE_Q, 0, 16'd1, 16'd1, ONE_Q, 0, -ONE_Q, 0));
        add_row(mk_pair(-ONE_Q, 0, 16'd1, 16'd1, ONE_Q, 0, -ONE_Q, 0));
        // one mass zero on each side
        add_row(mk_pair(0, ONE_Q, 16'd0, 16'd10, 0, ONE_Q, 0, -ONE_Q));
        add_row(mk_pair(0, ONE_Q, 16'd10, 16'd0, 0, ONE_Q, 0, -ONE_Q));
        // extreme directions and masses
        add_row(mk_pair(V_MAX, V_MAX, 16'hFFFF, 16'hFFFF, V_MAX, V_MAX, V_MIN, V_MIN));
        add_row(mk_pair(V_MIN, V_MIN, 16'd1, 16'hFFFF, V_MIN, V_MAX, V_MAX, V_MIN));
        add_row(mk_pair(V_MIN, V_MAX, 16'hFFFF, 16'd1, V_MAX, V_MIN, V_MIN, V_MAX));
        add_row(mk_pair(24'sd1, 0, 16'd1, 16'd1, V_MAX, 0, V_MIN, 0));
        add_row(mk_pair(24'sd1, 24'sd1, 16'd3, 16'd1, 24'sd1, 0, 0, 24'sd1));
        // tiny differences exercise the rounding
        add_row(mk_pair(24'sd3, 24'sd7, 16'd3, 16'd5, 24'sd1, -24'sd2, 24'sd5, 24'sd3));
        add_row(mk_pair(V_MAX, 24'sd1, 16'd2, 16'd3, 24'sd1, 0, 0, 0));
        // saturation on the way out
        add_row(mk_pair(ONE_Q, 0, 16'd1, 16'hFFFF, V_MIN, 0, V_MAX, 0));
        add_row(mk_pair(ONE_Q, ONE_Q, 16'hFFFF, 16'd1, V_MAX, V_MAX, V_MIN, V_MIN));

        foreach (directed[i])
            send_pair(directed[i].pair, directed[i].typed, directed[i].want);

        rest_plan[0] = 17'd0;
        rest_plan[1] = REST_ONE;
        rest_plan[2] = 17'h1FFFF;        // above one, clamps
        rest_plan[3] = REST_W'($urandom_range(0, 17'h1FFFF));
        rest_plan[4] = REST_W'($urandom_range(1, 65535));
        rest_plan[5] = REST_RESET;

        n_sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            write_rest(rest_plan[ph]);
            for (int i = 0; i < N_RANDOM / 6; i++)
            begin
                // switch between bursty and idle stretches every so often
                if (i % 40 == 0)
                begin
                    tx_busy_mode = ($urandom_range(0, 3) == 0);
                    rx_busy_mode = ($urandom_range(0, 3) == 0);
                end
                send_pair(rand_pair(), 1'b0, none);
                n_sent = n_sent + 1;
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        drain();

        if (n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
